// ----- hw/rtl/lkcd_pkg.sv -----
// ----------------------------------------------------------------------------
// lkcd_pkg
// Types and constants shared by the LRU key cache directory.
// ----------------------------------------------------------------------------
package lkcd_pkg;

  localparam int unsigned KeyW   = 16;
  localparam int unsigned StampW = 32;
  localparam int unsigned SlotW  = 3;

  localparam logic OpGet   = 1'b0;
  localparam logic OpClear = 1'b1;

  typedef struct packed {
    logic            op;
    logic [KeyW-1:0] key;
  } req_t;

  typedef struct packed {
    logic [SlotW-1:0] slot;
    logic             hit;
    logic             load_needed;
    logic             cleared;
  } rsp_t;

endpackage

// ----- hw/rtl/lru_key_cache_directory.sv -----
// ----------------------------------------------------------------------------
// lru_key_cache_directory
// Fully associative cache directory with LRU replacement by use stamps.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (in_valid_i / in_stall_o / in_data_i) carries op and key.
//   Response channel (out_valid_o / out_stall_i / out_data_o) returns one
//   transaction per request: slot, hit, load_needed, cleared.
//   Keys sit in a compare array, stamps in a synchronous RAM.
//   One request is processed at a time.
//   Get hit and clear: accept, then compare and update. Get miss: accept,
//   compare, then read the stamp RAM one entry per cycle to find the oldest
//   slot, as it has a single read port, then fill.
//   The response appears in the output register the cycle after completion;
//   a new request is taken while that response still waits.
//   A stalled response holds; a request finishing meanwhile waits for the
//   output register to free.
//   Reset clears keys, stamp valid bits and the use counter; no clearing
//   pass is needed.
// ----------------------------------------------------------------------------
module lru_key_cache_directory import lkcd_pkg::*; #(
  parameter int unsigned ENTRIES = 8
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  req_t in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output rsp_t out_data_o
);

  localparam int unsigned IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [IW-1:0] LastIdx = IW'(ENTRIES - 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_LOOK = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;
  localparam logic [1:0] S_FILL = 2'd3;

  logic [1:0]         state_q, state_d;
  req_t               req_q;
  logic [StampW-1:0]  cnt_q, cnt_d;
  logic [ENTRIES-1:0] sval_q, sval_d;
  logic [IW-1:0]      cmp_q, cmp_d;
  logic [IW-1:0]      best_idx_q, best_idx_d;
  logic [StampW-1:0]  best_q, best_d;
  logic               out_valid_q, out_valid_d;
  rsp_t               out_q, out_d;

  logic [StampW-1:0]  mem [ENTRIES];
  logic [StampW-1:0]  rd_data_q;
  logic [IW-1:0]      rd_addr;
  logic               mem_we;
  logic [IW-1:0]      mem_waddr;
  logic [StampW-1:0]  cur_stamp;

  logic               match;
  logic [IW-1:0]      match_idx;
  logic               cam_we;
  logic [IW-1:0]      cam_waddr;
  logic [KeyW-1:0]    cam_wkey;

  logic               out_free;
  logic [StampW-1:0]  cnt_inc;

  lkcd_cam #(
    .ENTRIES (ENTRIES),
    .IW      (IW)
  ) u_cam (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .search_key_i (req_q.key),
    .match_o      (match),
    .match_idx_o  (match_idx),
    .we_i         (cam_we),
    .waddr_i      (cam_waddr),
    .wkey_i       (cam_wkey)
  );

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= cnt_q;
    end
    rd_data_q <= mem[rd_addr];
  end

  assign rd_addr    = (state_q == S_LOOK) ? '0 : cmp_q + 1'b1;
  assign cur_stamp  = sval_q[cmp_q] ? rd_data_q : '0;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign cnt_inc    = (cnt_q != '1) ? cnt_q + 1'b1 : cnt_q;
  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    sval_d      = sval_q;
    cmp_d       = cmp_q;
    best_idx_d  = best_idx_q;
    best_d      = best_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    mem_we      = 1'b0;
    mem_waddr   = match_idx;
    cam_we      = 1'b0;
    cam_waddr   = match_idx;
    cam_wkey    = '0;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_LOOK;
        end
      end
      S_LOOK: begin
        if (req_q.op == OpGet && !match) begin
          cmp_d   = '0;
          state_d = S_SCAN;
        end else if (out_free) begin
          out_valid_d = 1'b1;
          out_d       = '0;
          state_d     = S_IDLE;
          if (req_q.op == OpGet) begin
            mem_we            = 1'b1;
            sval_d[match_idx] = 1'b1;
            cnt_d             = cnt_inc;
            out_d.slot        = SlotW'(match_idx);
            out_d.hit         = 1'b1;
          end else if (match) begin
            cam_we            = 1'b1;
            sval_d[match_idx] = 1'b0;
            out_d.cleared     = 1'b1;
          end
        end
      end
      S_SCAN: begin
        if (cmp_q == '0 || cur_stamp < best_q) begin
          best_d     = cur_stamp;
          best_idx_d = cmp_q;
        end
        if (cmp_q == LastIdx) begin
          state_d = S_FILL;
        end else begin
          cmp_d = cmp_q + 1'b1;
        end
      end
      S_FILL: begin
        mem_waddr = best_idx_q;
        cam_waddr = best_idx_q;
        cam_wkey  = req_q.key;
        if (out_free) begin
          mem_we             = 1'b1;
          cam_we             = 1'b1;
          sval_d[best_idx_q] = 1'b1;
          cnt_d              = cnt_inc;
          out_valid_d        = 1'b1;
          out_d              = '0;
          out_d.slot         = SlotW'(best_idx_q);
          out_d.load_needed  = 1'b1;
          state_d            = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      sval_q      <= '0;
      cmp_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      sval_q      <= sval_d;
      cmp_q       <= cmp_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_valid_i) begin
      req_q <= in_data_i;
    end
    best_idx_q <= best_idx_d;
    best_q     <= best_d;
    out_q      <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_cnt_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> cnt_q >= $past(cnt_q))
    else $error("use counter went backward");

  a_rsp_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> $countones({out_q.hit, out_q.load_needed, out_q.cleared}) <= 1)
    else $error("response flags not exclusive");

  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SCAN |-> cmp_q <= LastIdx)
    else $error("scan index out of range");

  a_fill_after_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FILL && $past(state_q) != S_FILL) |-> $past(state_q) == S_SCAN)
    else $error("fill entered without scan");

endmodule

// ----- hw/rtl/lkcd_cam.sv -----
// ----------------------------------------------------------------------------
// lkcd_cam
// Key store with parallel compare and lowest-index priority encode.
// ----------------------------------------------------------------------------
module lkcd_cam import lkcd_pkg::*; #(
  parameter int unsigned ENTRIES = 8,
  parameter int unsigned IW      = $clog2(ENTRIES)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [KeyW-1:0] search_key_i,
  output logic            match_o,
  output logic [IW-1:0]   match_idx_o,
  input  logic            we_i,
  input  logic [IW-1:0]   waddr_i,
  input  logic [KeyW-1:0] wkey_i
);

  logic [KeyW-1:0] key_q [ENTRIES];
  logic [ENTRIES-1:0] hit_vec;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ENTRIES; i++) begin
        key_q[i] <= '0;
      end
    end else if (we_i) begin
      key_q[waddr_i] <= wkey_i;
    end
  end

  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      hit_vec[i] = (key_q[i] == search_key_i);
    end
  end

  always_comb begin
    match_idx_o = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (hit_vec[i]) begin
        match_idx_o = IW'(i);
      end
    end
  end

  assign match_o = |hit_vec;

endmodule
